// File: rtl/gru_pkg.sv
// Shared types and constants for the Givens rotation unit.
// Depends on nothing; imported by rtl/givens_rotation_unit.sv.
package gru_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CntWidth = 5;

  // Q1.30 one, reset value of the stored cosine.
  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  // Function codes.
  localparam logic FuncCompute = 1'b0;
  localparam logic FuncApply = 1'b1;

  typedef struct packed {
    logic func;
    logic signed [DataWidth-1:0] first_operand;
    logic signed [DataWidth-1:0] second_operand;
    logic last_pair;
  } gru_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] first_result;
    logic signed [DataWidth-1:0] second_result;
    logic last_out;
    logic saturated;
  } gru_out_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV_T = 8'b0000_0010,
    ST_SQR_T = 8'b0000_0100,
    ST_SQRT  = 8'b0000_1000,
    ST_DIV_M = 8'b0001_0000,
    ST_MUL_O = 8'b0010_0000,
    ST_APPLY = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } gru_state_e;

endpackage

// File: rtl/givens_rotation_unit.sv
// Givens plane-rotation unit: bit-serial divide, square root and multiply.
// Depends on rtl/gru_pkg.sv.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | in_req_i  (gru_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_req_o (gru_out_t)
//
// A compute request runs divide, square, root, divide, multiply and hand-over in
// that order, or goes straight to hand-over when the second operand is zero; an
// apply request runs multiply and hand-over. The next request is taken in the
// cycle after the hand-over.
// All of this is one shared shift-add multiplier, one restoring divider and one
// restoring square-root datapath, each retiring one bit per cycle.
// Reset restores cosine 1.0 and sine 0 and empties the output register.
// A new request is taken while a finished result waits; the block stalls input
// only while a request is being worked on or its result cannot be handed over.
module givens_rotation_unit
  import gru_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gru_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gru_out_t out_req_o
);

  gru_state_e state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  logic func_q, func_d, last_q, last_d, neg_q, neg_d, bbig_q, bbig_d;
  logic signed [31:0] cos_q, cos_d, sin_q, sin_d;
  logic signed [31:0] res1_q, res1_d, res2_q, res2_d;
  logic sat_q, sat_d;

  // Serial multiplier state.
  logic [31:0] mc_q, mc_d, ms_q, ms_d;
  logic signed [31:0] x_q, x_d, y_q, y_d;
  logic signed [34:0] acc1_q, acc1_d, acc2_q, acc2_d;
  logic [31:0] lo1_q, lo1_d, lo2_q, lo2_d;

  // Divider and square root state.
  logic [32:0] drem_q, drem_d;
  logic [31:0] ddiv_q, ddiv_d;
  logic [30:0] quo_q, quo_d;
  logic [30:0] t_q, t_d;
  logic [61:0] sv_q, sv_d;
  logic [34:0] srem_q, srem_d;
  logic [30:0] root_q, root_d;

  logic out_valid_q, out_valid_d;
  gru_out_t out_q, out_d;

  // Multiplier step, one multiplier bit per cycle, sign bit weighted negative.
  logic mul_last;
  logic signed [34:0] xe, ye, add1, add2, sum1, sum2;
  always_comb begin
    mul_last = (cnt_q == {CntWidth{1'b1}});
    xe = 35'(x_q);
    ye = 35'(y_q);
    add1 = (mc_q[0] ? xe : 35'sd0) + (ms_q[0] ? ye : 35'sd0);
    add2 = (mc_q[0] ? ye : 35'sd0) - (ms_q[0] ? xe : 35'sd0);
    if (mul_last) begin
      add1 = -add1;
      add2 = -add2;
    end
    sum1 = acc1_q + add1;
    sum2 = acc2_q + add2;
  end

  // Divider step: first step compares without shifting.
  logic [32:0] dsh;
  logic dge;
  logic [30:0] quo_n;
  always_comb begin
    dsh = (cnt_q == '0) ? drem_q : {drem_q[31:0], 1'b0};
    dge = (dsh >= {1'b0, ddiv_q});
    quo_n = {quo_q[29:0], dge};
  end

  // Square root step: two radicand bits per cycle.
  logic [34:0] ssh, strial;
  logic sge;
  always_comb begin
    ssh = {srem_q[32:0], sv_q[61:60]};
    strial = {2'b00, root_q, 2'b01};
    sge = (ssh >= strial);
  end

  // Results at the end of a multiply pass.
  logic signed [36:0] fx, fy;
  logic [30:0] o_val;
  logic signed [31:0] o_sgn;
  logic ovx, unx, ovy, uny;
  always_comb begin
    fx = {sum1[35-1], sum1[34:1], sum1[0], lo1_q[31]};
    fy = {sum2[35-1], sum2[34:1], sum2[0], lo2_q[31]};
    o_val = {sum1[29:1], sum1[0], lo1_q[31]};
    o_sgn = neg_q ? -$signed({1'b0, o_val}) : $signed({1'b0, o_val});
    ovx = !fx[36] && (|fx[35:31]);
    unx = fx[36] && !(&fx[35:31]);
    ovy = !fy[36] && (|fy[35:31]);
    uny = fy[36] && !(&fy[35:31]);
  end

  // Operand magnitudes at accept.
  logic [31:0] mag_a, mag_b;
  logic in_bbig;
  always_comb begin
    mag_a = in_req_i.first_operand[31] ? 32'(-in_req_i.first_operand)
                                       : 32'(in_req_i.first_operand);
    mag_b = in_req_i.second_operand[31] ? 32'(-in_req_i.second_operand)
                                        : 32'(in_req_i.second_operand);
    in_bbig = (mag_b > mag_a);
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer and datapath next state.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q + 1'b1;
    func_d = func_q; last_d = last_q; neg_d = neg_q; bbig_d = bbig_q;
    cos_d = cos_q; sin_d = sin_q; res1_d = res1_q; res2_d = res2_q; sat_d = sat_q;
    mc_d = mc_q >> 1; ms_d = ms_q >> 1; x_d = x_q; y_d = y_q;
    acc1_d = sum1 >>> 1; acc2_d = sum2 >>> 1;
    lo1_d = {sum1[0], lo1_q[31:1]}; lo2_d = {sum2[0], lo2_q[31:1]};
    drem_d = dge ? (dsh - {1'b0, ddiv_q}) : dsh; ddiv_d = ddiv_q; quo_d = quo_n;
    t_d = t_q;
    sv_d = {sv_q[59:0], 2'b00};
    srem_d = sge ? (ssh - strial) : ssh;
    root_d = {root_q[29:0], sge};
    out_valid_d = out_valid_q && out_stall_i; out_d = out_q;

    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          func_d = in_req_i.func;
          last_d = in_req_i.last_pair;
          x_d = in_req_i.first_operand;
          y_d = in_req_i.second_operand;
          acc1_d = '0; acc2_d = '0;
          mc_d = cos_q; ms_d = sin_q;
          neg_d = (in_req_i.first_operand[31] == in_req_i.second_operand[31]);
          bbig_d = in_bbig;
          drem_d = {1'b0, in_bbig ? mag_a : mag_b};
          ddiv_d = in_bbig ? mag_b : mag_a;
          quo_d = '0;
          sat_d = 1'b0;
          if (in_req_i.func == FuncApply) begin
            state_d = ST_APPLY;
          end else if (in_req_i.second_operand == '0) begin
            cos_d = OneQ30; sin_d = '0;
            res1_d = OneQ30; res2_d = '0;
            state_d = ST_FIN;
          end else begin
            state_d = ST_DIV_T;
          end
        end
      end
      ST_DIV_T: begin
        if (cnt_q == CntWidth'(30)) begin
          t_d = quo_n;
          mc_d = {1'b0, quo_n}; ms_d = '0;
          x_d = $signed({1'b0, quo_n}); y_d = '0;
          acc1_d = '0; acc2_d = '0;
          cnt_d = '0;
          state_d = ST_SQR_T;
        end
      end
      ST_SQR_T: begin
        if (mul_last) begin
          sv_d = {sum1[30:0], lo1_q[31:1]} + (62'd1 << 60);
          srem_d = '0; root_d = '0;
          cnt_d = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_q == CntWidth'(30)) begin
          drem_d = 33'd1 << 30;
          ddiv_d = {1'b0, root_d};
          quo_d = '0;
          cnt_d = '0;
          state_d = ST_DIV_M;
        end
      end
      ST_DIV_M: begin
        if (cnt_q == CntWidth'(30)) begin
          mc_d = {1'b0, quo_n}; ms_d = '0;
          x_d = $signed({1'b0, t_q}); y_d = '0;
          acc1_d = '0; acc2_d = '0;
          res1_d = $signed({1'b0, quo_n});
          cnt_d = '0;
          state_d = ST_MUL_O;
        end
      end
      ST_MUL_O: begin
        if (mul_last) begin
          if (bbig_q) begin
            res1_d = o_sgn; res2_d = res1_q;
            cos_d = o_sgn; sin_d = res1_q;
          end else begin
            res2_d = o_sgn;
            cos_d = res1_q; sin_d = o_sgn;
          end
          state_d = ST_FIN;
        end
      end
      ST_APPLY: begin
        if (mul_last) begin
          res1_d = ovx ? 32'sh7fff_ffff : (unx ? 32'sh8000_0000 : fx[31:0]);
          res2_d = ovy ? 32'sh7fff_ffff : (uny ? 32'sh8000_0000 : fy[31:0]);
          sat_d = ovx || unx || ovy || uny;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cnt_d = '0;
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.first_result = res1_q;
          out_d.second_result = res2_q;
          out_d.last_out = last_q;
          out_d.saturated = sat_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      cos_q <= OneQ30;
      sin_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    func_q <= func_d; last_q <= last_d; neg_q <= neg_d; bbig_q <= bbig_d;
    res1_q <= res1_d; res2_q <= res2_d; sat_q <= sat_d;
    mc_q <= mc_d; ms_q <= ms_d; x_q <= x_d; y_q <= y_d;
    acc1_q <= acc1_d; acc2_q <= acc2_d; lo1_q <= lo1_d; lo2_q <= lo2_d;
    drem_q <= drem_d; ddiv_q <= ddiv_d; quo_q <= quo_d; t_q <= t_d;
    sv_q <= sv_d; srem_q <= srem_d; root_q <= root_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o = out_q;

  // A result only appears out of the finishing state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result appeared outside finish state");

  // Divide and root passes never run past their last bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_T || state_q == ST_SQRT || state_q == ST_DIV_M)
      |-> cnt_q <= CntWidth'(30))
    else $error("bit counter overran a divide or root pass");

  // Compute requests never report saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && func_q == FuncCompute) |-> !sat_q)
    else $error("saturation flagged on compute request");

  // The finishing state hands over whenever the output slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_valid_q) |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished result not handed over");

endmodule
